// ===== hw/rtl/ldu_pkg.sv =====
// ----------------------------------------------------------------------------
// ldu_pkg: shared types and constants for the lens undistortion block
// Coordinate format, register indexes, sequencer states, operation codes.
// ----------------------------------------------------------------------------
`default_nettype none
package ldu_pkg;
	localparam int CoordW = 32;
	localparam int FracW = 28;
	localparam int IterLimit = 64;
	localparam int IterW = 7;
	localparam int TolW = 31;
	localparam int CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] RegK1 = 3'd0;
	localparam logic [CfgIdxW-1:0] RegK2 = 3'd1;
	localparam logic [CfgIdxW-1:0] RegK3 = 3'd2;
	localparam logic [CfgIdxW-1:0] RegP1 = 3'd3;
	localparam logic [CfgIdxW-1:0] RegP2 = 3'd4;
	localparam logic [CfgIdxW-1:0] RegTol = 3'd5;
	localparam logic [CfgIdxW-1:0] RegIter = 3'd6;

	localparam logic signed [CoordW-1:0] VMax = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic signed [CoordW-1:0] VMin = {1'b1, {(CoordW-1){1'b0}}};
	localparam logic signed [CoordW-1:0] One = CoordW'(64'sd1 <<< FracW);

	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALU,
		ST_DIV,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic fwd_only;
		logic last_iter;
	} phase_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ldu_div.sv =====
// ----------------------------------------------------------------------------
// ldu_div: radix-2 fixed-point divider
// Rounded signed quotient of a by b with saturation, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ldu_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic signed [ldu_pkg::CoordW-1:0] a,
	input wire logic signed [ldu_pkg::CoordW-1:0] b,
	output logic done,
	output logic signed [ldu_pkg::CoordW-1:0] q,
	output logic ovf
);
	import ldu_pkg::*;
	localparam int NumW = CoordW + FracW;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] num_q;
	logic [NumW-1:0] quo_q;
	logic [CoordW:0] rem_q;
	logic [CoordW-1:0] den_q;
	logic neg_q;
	logic [CntW-1:0] cnt_q;
	logic run_q;
	logic fin_q;

	logic [CoordW:0] rsh;
	logic [CoordW:0] rsub;
	logic [NumW:0] qr;
	logic [CoordW:0] lim;
	logic big;

	assign rsh = {rem_q[CoordW-1:0], num_q[NumW-1]};
	assign rsub = rsh - {1'b0, den_q};
	assign qr = {1'b0, quo_q} + ((rem_q >= ({1'b0, den_q} - rem_q)) ? 1'b1 : 1'b0);
	assign lim = neg_q ? {1'b0, VMin} : {1'b0, VMax};
	assign big = (qr > {{(NumW-CoordW){1'b0}}, lim});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= (b != '0);
				fin_q <= (b == '0);
				cnt_q <= CntW'(NumW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= {(a[CoordW-1] ? CoordW'(-a) : CoordW'(a)), {FracW{1'b0}}};
			den_q <= b[CoordW-1] ? CoordW'(-b) : CoordW'(b);
			neg_q <= a[CoordW-1] ^ b[CoordW-1];
			rem_q <= '0;
			quo_q <= '0;
			if (b == '0) neg_q <= a[CoordW-1];
		end else if (run_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!rsub[CoordW]) begin
				rem_q <= rsub;
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rsh;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		done = fin_q;
		if (den_q == '0) begin
			ovf = 1'b1;
			q = neg_q ? VMin : VMax;
		end else if (big) begin
			ovf = 1'b1;
			q = neg_q ? VMin : VMax;
		end else begin
			ovf = 1'b0;
			q = neg_q ? CoordW'(-qr[CoordW-1:0]) : qr[CoordW-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lens_distortion_undistort.sv =====
// ----------------------------------------------------------------------------
// lens_distortion_undistort: iterative Brown-Conrady inverse
// Fixed-point iteration using one shared multiply/add unit and a serial divider.
// ----------------------------------------------------------------------------
// Pass-through when all coefficients are zero; otherwise a run of iterations
//   followed by a final residual check and result.
// Throughput: one point at a time, accepted only while idle; the shared ALU and divider set it.
// Reset clears the registers to defaults (tolerance 1, 20 iterations).
// done pulses one cycle with the result; the receiver cannot stall.
`default_nettype none
module lens_distortion_undistort (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [ldu_pkg::CoordW-1:0] x_distorted,
	input wire logic signed [ldu_pkg::CoordW-1:0] y_distorted,
	output logic done,
	output logic signed [ldu_pkg::CoordW-1:0] x_undistorted,
	output logic signed [ldu_pkg::CoordW-1:0] y_undistorted,
	output logic status,
	output logic [ldu_pkg::IterW-1:0] iterations_used,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [ldu_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [ldu_pkg::CoordW-1:0] cfg_data
);
	import ldu_pkg::*;

	// micro-program: op, result reg index, operand a, operand b
	localparam int NReg = 24;
	localparam int RW = 5;
	localparam logic [RW-1:0] R_ZERO = 5'd0, R_ONE = 5'd1, R_K1 = 5'd2, R_K2 = 5'd3,
		R_K3 = 5'd4, R_P1 = 5'd5, R_P2 = 5'd6, R_XD = 5'd7, R_YD = 5'd8, R_X = 5'd9,
		R_Y = 5'd10, R_XX = 5'd11, R_YY = 5'd12, R_XY = 5'd13, R_R2 = 5'd14,
		R_PL = 5'd15, R_RD = 5'd16, R_A = 5'd17, R_B = 5'd18, R_T = 5'd19,
		R_TX = 5'd20, R_TY = 5'd21, R_NX = 5'd22, R_NY = 5'd23;
	localparam int NFwd = 24;
	localparam int PcW = 5;

	typedef struct packed {
		op_t op;
		logic [RW-1:0] d;
		logic [RW-1:0] a;
		logic [RW-1:0] b;
	} uop_t;

	function automatic uop_t fwd_rom(input logic [PcW-1:0] pc);
		uop_t u;
		u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
		case (pc)
			5'd0: u = '{OP_MUL, R_XX, R_X, R_X};
			5'd1: u = '{OP_MUL, R_YY, R_Y, R_Y};
			5'd2: u = '{OP_MUL, R_XY, R_X, R_Y};
			5'd3: u = '{OP_ADD, R_R2, R_XX, R_YY};
			5'd4: u = '{OP_MUL, R_PL, R_R2, R_K3};
			5'd5: u = '{OP_ADD, R_PL, R_K2, R_PL};
			5'd6: u = '{OP_MUL, R_PL, R_R2, R_PL};
			5'd7: u = '{OP_ADD, R_PL, R_K1, R_PL};
			5'd8: u = '{OP_MUL, R_PL, R_R2, R_PL};
			5'd9: u = '{OP_ADD, R_RD, R_ONE, R_PL};
			5'd10: u = '{OP_MUL, R_A, R_P1, R_XY};
			5'd11: u = '{OP_MUL, R_B, R_P2, R_XY};
			5'd12: u = '{OP_ADD, R_T, R_XX, R_XX};
			5'd13: u = '{OP_ADD, R_T, R_R2, R_T};
			5'd14: u = '{OP_MUL, R_T, R_P2, R_T};
			5'd15: u = '{OP_ADD, R_TX, R_A, R_A};
			5'd16: u = '{OP_ADD, R_TX, R_TX, R_T};
			5'd17: u = '{OP_ADD, R_T, R_YY, R_YY};
			5'd18: u = '{OP_ADD, R_T, R_R2, R_T};
			5'd19: u = '{OP_MUL, R_TY, R_P1, R_T};
			5'd20: u = '{OP_ADD, R_T, R_B, R_B};
			5'd21: u = '{OP_ADD, R_TY, R_TY, R_T};
			5'd22: u = '{OP_SUB, R_NX, R_XD, R_TX};
			5'd23: u = '{OP_SUB, R_NY, R_YD, R_TY};
			default: u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
		endcase
		return u;
	endfunction

	function automatic uop_t res_rom(input logic [PcW-1:0] pc);
		uop_t u;
		case (pc)
			5'd0: u = '{OP_MUL, R_NX, R_X, R_RD};
			5'd1: u = '{OP_ADD, R_NX, R_NX, R_TX};
			5'd2: u = '{OP_MUL, R_NY, R_Y, R_RD};
			5'd3: u = '{OP_ADD, R_NY, R_NY, R_TY};
			default: u = '{OP_ADD, R_ZERO, R_ZERO, R_ZERO};
		endcase
		return u;
	endfunction

	state_t state_q, state_d;
	phase_t ph_q;
	logic [PcW-1:0] pc_q;
	logic [1:0] sub_q;
	logic signed [CoordW-1:0] rf_q [NReg];
	logic signed [CoordW-1:0] k_q [5];
	logic [TolW-1:0] tol_q;
	logic [IterW-1:0] iter_cfg_q;
	logic [IterW-1:0] n_q, used_q;
	logic ovf_q;
	logic dv_sel_q;
	logic dv_go_q;
	logic [2*CoordW+1:0] sq_q;
	logic signed [CoordW-1:0] xo_q, yo_q;
	logic st_q, done_q;

	uop_t u;
	logic signed [CoordW-1:0] opa, opb;
	logic [CoordW-1:0] amag, bmag;
	logic signed [CoordW+1:0] sum;
	logic [2*CoordW-1:0] pmag;
	logic [2*CoordW-FracW:0] pr;
	logic pneg;
	logic signed [CoordW-1:0] alu_r;
	logic alu_ovf;
	logic dv_done, dv_ovf;
	logic signed [CoordW-1:0] dv_q;
	logic signed [CoordW:0] dlt;
	logic [CoordW:0] dmag;
	logic [2*CoordW+1:0] dsq;
	logic [2*TolW-1:0] tol2;
	logic last_uop;
	logic allzero;
	logic [RW-1:0] sqa, sqb;

	assign allzero = (k_q[0] | k_q[1] | k_q[2] | k_q[3] | k_q[4]) == '0;
	assign tol2 = tol_q * tol_q;
	assign u = ph_q.fwd_only && pc_q >= PcW'(NFwd) ? res_rom(pc_q - PcW'(NFwd))
		: fwd_rom(pc_q);
	assign last_uop = ph_q.fwd_only ? (pc_q == PcW'(NFwd + 3)) : (pc_q == PcW'(NFwd - 1));
	assign opa = rf_q[u.a];
	assign opb = rf_q[u.b];

	// shared ALU: signed Q-format multiply with round-half-away, or saturating add or subtract
	assign pneg = opa[CoordW-1] ^ opb[CoordW-1];
	assign amag = opa[CoordW-1] ? CoordW'(-opa) : CoordW'(opa);
	assign bmag = opb[CoordW-1] ? CoordW'(-opb) : CoordW'(opb);
	assign pmag = (2*CoordW)'(amag) * (2*CoordW)'(bmag);
	assign pr = (2*CoordW-FracW+1)'((pmag + (2*CoordW)'(64'd1 << (FracW-1))) >> FracW);
	assign sum = (u.op == OP_SUB) ? (CoordW+2)'(opa) - (CoordW+2)'(opb)
		: (CoordW+2)'(opa) + (CoordW+2)'(opb);

	always_comb begin
		alu_ovf = 1'b0;
		alu_r = sum[CoordW-1:0];
		case (u.op)
			OP_MUL: begin
				if (!pneg && pr > (2*CoordW-FracW+1)'(VMax)) begin
					alu_ovf = 1'b1;
					alu_r = VMax;
				end else if (pneg && pr > (2*CoordW-FracW+1)'({1'b0, VMin})) begin
					alu_ovf = 1'b1;
					alu_r = VMin;
				end else begin
					alu_r = pneg ? CoordW'(-pr[CoordW-1:0]) : pr[CoordW-1:0];
				end
			end
			default: begin
				if (sum > (CoordW+2)'(VMax)) begin
					alu_ovf = 1'b1;
					alu_r = VMax;
				end else if (sum < (CoordW+2)'(VMin)) begin
					alu_ovf = 1'b1;
					alu_r = VMin;
				end
			end
		endcase
	end

	ldu_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(dv_go_q),
		.a(dv_sel_q ? rf_q[R_NY] : rf_q[R_NX]),
		.b(rf_q[R_RD]),
		.done(dv_done),
		.q(dv_q),
		.ovf(dv_ovf)
	);

	// one squared term per cycle: sub_q 0 -> x term, 1 -> y term
	always_comb begin
		if (ph_q.fwd_only) begin
			sqa = sub_q[0] ? R_NY : R_NX;
			sqb = sub_q[0] ? R_YD : R_XD;
		end else begin
			sqa = sub_q[0] ? R_NY : R_NX;
			sqb = sub_q[0] ? R_Y : R_X;
		end
	end
	assign dlt = (CoordW+1)'(rf_q[sqa]) - (CoordW+1)'(rf_q[sqb]);
	assign dmag = dlt[CoordW] ? (CoordW+1)'(-dlt) : dlt;
	assign dsq = (2*CoordW+2)'(dmag) * (2*CoordW+2)'(dmag);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = allzero ? ST_DONE : ST_ALU;
			ST_ALU: if (last_uop) state_d = ph_q.fwd_only ? ST_STEP : ST_DIV;
			ST_DIV: if (dv_done && dv_sel_q) state_d = ST_STEP;
			ST_STEP: if (sub_q == 2'd2) state_d = ph_q.fwd_only ? ST_DONE : ST_ALU;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 5; i++) k_q[i] <= '0;
			tol_q <= TolW'(1);
			iter_cfg_q <= IterW'(20);
			done_q <= 1'b0;
			dv_go_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == ST_DONE);
			dv_go_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					RegK1, RegK2, RegK3, RegP1, RegP2: k_q[cfg_index] <= cfg_data;
					RegTol: tol_q <= cfg_data[TolW-1:0];
					RegIter: iter_cfg_q <= cfg_data[IterW-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_ALU && last_uop && !ph_q.fwd_only) dv_go_q <= 1'b1;
			if (state_q == ST_DIV && dv_done && !dv_sel_q) dv_go_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rf_q[R_ZERO] <= '0;
				rf_q[R_ONE] <= One;
				for (int i = 0; i < 5; i++) rf_q[R_K1 + RW'(i)] <= k_q[i];
				rf_q[R_XD] <= x_distorted;
				rf_q[R_YD] <= y_distorted;
				rf_q[R_X] <= x_distorted;
				rf_q[R_Y] <= y_distorted;
				n_q <= (iter_cfg_q > IterW'(IterLimit)) ? IterW'(IterLimit) : iter_cfg_q;
				used_q <= '0;
				ovf_q <= 1'b0;
				pc_q <= '0;
				sub_q <= '0;
				dv_sel_q <= 1'b0;
				sq_q <= '0;
				ph_q.fwd_only <= (iter_cfg_q == '0);
				ph_q.last_iter <= 1'b0;
				st_q <= 1'b0;
				xo_q <= x_distorted;
				yo_q <= y_distorted;
			end
			ST_ALU: begin
				rf_q[u.d] <= alu_r;
				ovf_q <= ovf_q | alu_ovf;
				// skip the step numerators on the residual pass
				pc_q <= last_uop ? '0
					: (ph_q.fwd_only && pc_q == PcW'(NFwd - 3)) ? PcW'(NFwd)
					: pc_q + 1'b1;
				sub_q <= '0;
				sq_q <= '0;
			end
			ST_DIV: begin
				if (dv_done) begin
					rf_q[dv_sel_q ? R_NY : R_NX] <= dv_q;
					ovf_q <= ovf_q | dv_ovf;
					dv_sel_q <= ~dv_sel_q;
				end
			end
			ST_STEP: begin
				if (sub_q != 2'd2) begin
					sq_q <= sq_q + dsq;
					sub_q <= sub_q + 1'b1;
				end else if (ph_q.fwd_only) begin
					st_q <= ovf_q || (sq_q > (2*CoordW+2)'(tol2));
					xo_q <= rf_q[R_X];
					yo_q <= rf_q[R_Y];
				end else begin
					rf_q[R_X] <= rf_q[R_NX];
					rf_q[R_Y] <= rf_q[R_NY];
					used_q <= used_q + 1'b1;
					if (ovf_q || sq_q < (2*CoordW+2)'(tol2) || used_q + 1'b1 == n_q)
						ph_q.fwd_only <= 1'b1;
				end
			end
			ST_DONE: begin
				if (allzero) begin
					st_q <= 1'b0;
					used_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		cfg_ready = (state_q == ST_IDLE);
		done = done_q;
		x_undistorted = xo_q;
		y_undistorted = yo_q;
		status = st_q;
		iterations_used = used_q;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ldu_checker.sv =====
// ----------------------------------------------------------------------------
// ldu_checker: port-level checks for the undistortion block
// Watches start/busy/done sequencing, config gating and result codes.
// ----------------------------------------------------------------------------
`default_nettype none
module ldu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic status,
	input wire logic [ldu_pkg::IterW-1:0] iterations_used,
	input wire logic cfg_ready
);
	import ldu_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept without busy");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> iterations_used <= IterW'(IterLimit)) else $error("iterations out of range");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("config open while busy");
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({status, iterations_used})) else $error("unknown result code");
endmodule

bind lens_distortion_undistort ldu_checker u_ldu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.iterations_used(iterations_used),
	.cfg_ready(cfg_ready)
);
`default_nettype wire

// ===== tb/tb_lens_distortion_undistort.sv =====
// ----------------------------------------------------------------------------
// tb_lens_distortion_undistort: self-checking bench for the undistortion block
// Drives points and coefficient settings with random spacing, predicts each
// undistorted point in fixed point, and checks every result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_lens_distortion_undistort;
	import ldu_pkg::*;

	localparam longint CycleLimit = 64'd60_000_000;
	localparam int PointCount = 1150;

	typedef struct {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic st;
		logic [IterW-1:0] used;
	} point_result_t;

	class undistort_scoreboard;
		logic signed [CoordW-1:0] coef[5];
		logic [TolW-1:0] tol;
		logic [IterW-1:0] iters;
		bit ovf;
		int errors;
		point_result_t pending[$];

		function new();
			foreach (coef[j]) coef[j] = '0;
			tol = TolW'(1);
			iters = IterW'(20);
			errors = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
			case (idx)
				RegK1: coef[0] = data;
				RegK2: coef[1] = data;
				RegK3: coef[2] = data;
				RegP1: coef[3] = data;
				RegP2: coef[4] = data;
				RegTol: tol = data[TolW-1:0];
				RegIter: iters = data[IterW-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v);
			if (v > 64'sd2147483647) begin
				ovf = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				ovf = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function logic [127:0] mag(longint v);
			longint u;
			u = v < 0 ? -v : v;
			return {64'd0, u};
		endfunction

		function longint from_mag(logic [127:0] m, bit neg);
			logic [127:0] lim;
			lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
			if (m > lim) begin
				ovf = 1;
				return neg ? -64'sd2147483648 : 64'sd2147483647;
			end
			return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
		endfunction

		function longint fmul(longint a, longint b);
			logic [127:0] p;
			p = mag(a) * mag(b) + (128'd1 << (FracW - 1));
			return from_mag(p >> FracW, (a < 0) != (b < 0));
		endfunction

		function longint fdiv(longint a, longint b);
			logic [127:0] num, d, q, r;
			if (b == 0) begin
				ovf = 1;
				return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
			end
			num = mag(a) << FracW;
			d = mag(b);
			q = num / d;
			r = num % d;
			if (r >= d - r) q = q + 1;
			return from_mag(q, (a < 0) != (b < 0));
		endfunction

		function logic [127:0] sqsum(longint a, longint b);
			return mag(a) * mag(a) + mag(b) * mag(b);
		endfunction

		function void distort(input longint k[5], input longint x, input longint y,
				output longint rd, output longint tx, output longint ty);
			longint xx, yy, xy, r2, poly, a, b;
			xx = fmul(x, x);
			yy = fmul(y, y);
			xy = fmul(x, y);
			r2 = clamp(xx + yy);
			poly = clamp(k[1] + fmul(r2, k[2]));
			poly = clamp(k[0] + fmul(r2, poly));
			rd = clamp(longint'(One) + fmul(r2, poly));
			a = fmul(k[3], xy);
			b = fmul(k[4], xy);
			tx = clamp(clamp(a + a) + fmul(k[4], clamp(r2 + clamp(xx + xx))));
			ty = clamp(fmul(k[3], clamp(r2 + clamp(yy + yy))) + clamp(b + b));
		endfunction

		function void note(logic signed [CoordW-1:0] xin, logic signed [CoordW-1:0] yin);
			point_result_t res;
			longint k[5];
			longint xd, yd, x, y, xn, yn, rd, tx, ty, fx, fy;
			logic [127:0] tol2, stp;
			int n;
			bit fail;
			res.x = xin;
			res.y = yin;
			res.st = 0;
			res.used = 0;
			if ((coef[0] | coef[1] | coef[2] | coef[3] | coef[4]) == 0) begin
				pending.push_back(res);
				return;
			end
			ovf = 0;
			foreach (k[j]) k[j] = longint'(coef[j]);
			xd = longint'(xin);
			yd = longint'(yin);
			tol2 = {97'd0, tol} * {97'd0, tol};
			n = iters > IterLimit ? IterLimit : iters;
			x = xd;
			y = yd;
			for (int i = 0; i < n; i++) begin
				distort(k, x, y, rd, tx, ty);
				xn = fdiv(clamp(xd - tx), rd);
				yn = fdiv(clamp(yd - ty), rd);
				stp = sqsum(xn - x, yn - y);
				x = xn;
				y = yn;
				res.used = IterW'(i + 1);
				if (ovf || stp < tol2) break;
			end
			distort(k, x, y, rd, tx, ty);
			fx = clamp(fmul(x, rd) + tx);
			fy = clamp(fmul(y, rd) + ty);
			fail = ovf || (tol2 < sqsum(fx - xd, fy - yd));
			res.x = x[CoordW-1:0];
			res.y = y[CoordW-1:0];
			res.st = fail;
			pending.push_back(res);
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		task check(point_result_t got);
			point_result_t exp_res;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result x=%h y=%h", got.x, got.y));
				return;
			end
			exp_res = pending.pop_front();
			if (got.x !== exp_res.x)
				report($sformatf("x_undistorted %h, want %h", got.x, exp_res.x));
			if (got.y !== exp_res.y)
				report($sformatf("y_undistorted %h, want %h", got.y, exp_res.y));
			if (got.st !== exp_res.st)
				report($sformatf("status %b, want %b", got.st, exp_res.st));
			if (got.used !== exp_res.used)
				report($sformatf("iterations_used %0d, want %0d", got.used, exp_res.used));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic signed [CoordW-1:0] x_distorted = '0;
	logic signed [CoordW-1:0] y_distorted = '0;
	logic done;
	logic signed [CoordW-1:0] x_undistorted;
	logic signed [CoordW-1:0] y_undistorted;
	logic status;
	logic [IterW-1:0] iterations_used;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CoordW-1:0] cfg_data = '0;

	undistort_scoreboard sb = new();
	longint cycles = 0;
	int sent = 0;

	lens_distortion_undistort dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_distorted(x_distorted), .y_distorted(y_distorted),
		.done(done), .x_undistorted(x_undistorted), .y_undistorted(y_undistorted),
		.status(status), .iterations_used(iterations_used),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		point_result_t got;
		if (arst_n && done) begin
			got.x = x_undistorted;
			got.y = y_undistorted;
			got.st = status;
			got.used = iterations_used;
			sb.check(got);
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// call at a falling edge; returns at a falling edge
	task send_point(logic signed [CoordW-1:0] xv, logic signed [CoordW-1:0] yv);
		int gap;
		x_distorted = xv;
		y_distorted = yv;
		start = 1;
		do @(posedge clk); while (busy);
		sb.note(xv, yv);
		sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 0;
		repeat ($urandom_range(0, 3)) @(negedge clk);
	endtask

	// hold until every expected beat has arrived
	task drain();
		start = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task set_all(logic [CoordW-1:0] k1, logic [CoordW-1:0] k2, logic [CoordW-1:0] k3,
			logic [CoordW-1:0] p1, logic [CoordW-1:0] p2, logic [CoordW-1:0] tl,
			logic [CoordW-1:0] it);
		drain();
		write_reg(RegK1, k1);
		write_reg(RegK2, k2);
		write_reg(RegK3, k3);
		write_reg(RegP1, p1);
		write_reg(RegP2, p2);
		write_reg(RegTol, tl);
		write_reg(RegIter, it);
	endtask

	function logic [CoordW-1:0] rand_coef();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
		if (r < 80) return '0;
		return $urandom;
	endfunction

	function logic [CoordW-1:0] rand_point();
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
		return $urandom;
	endfunction

	initial begin
		int phase_len, r;
		logic [CoordW-1:0] it, tl;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// pass-through with reset coefficients
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point('0, -1);
		send_point(32'sh1234_5678, 32'shEDCB_A988);

		set_all(32'hFCCC_CCCD, 32'h0051_EB85, 32'hFFEB_851F, 32'h0002_0C4A,
			32'hFFFD_F3B6, 32'h0000_0100, 32'd20);
		send_point('0, '0);
		send_point(32'h0800_0000, 32'hF800_0000);
		send_point(32'h1000_0000, 32'h1000_0000);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF);

		// zero divisor: k1 = -1 at unit radius
		set_all(32'hF000_0000, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'd5);
		send_point(32'h1000_0000, '0);
		send_point('0, 32'hF000_0000);

		// zero iterations, residual test only
		set_all(32'h0100_0000, '0, '0, '0, 32'h0010_0000, 32'h0000_1000, 32'd0);
		send_point(32'h0400_0000, 32'h0200_0000);
		send_point('0, '0);

		// count above the limit, zero tolerance
		set_all(32'h0080_0000, 32'hFFC0_0000, 32'h0010_0000, 32'h0001_0000,
			32'h0001_0000, 32'h8000_0000, 32'd127);
		send_point(32'h0300_0000, 32'hFD00_0000);

		// extreme coefficients
		set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd64);
		send_point(32'h1000_0000, 32'h1000_0000);
		send_point(32'hFFFF_FFFF, 32'h0000_0001);

		while (sent < PointCount) begin
			r = $urandom_range(0, 99);
			if (r < 8) it = 0;
			else if (r < 14) it = $urandom_range(64, 127);
			else it = $urandom_range(1, 20);
			it[CoordW-1:IterW] = (CoordW-IterW)'($urandom);
			r = $urandom_range(0, 99);
			if (r < 40) tl = $urandom_range(0, 32'h0001_0000);
			else if (r < 55) tl = 0;
			else if (r < 75) tl = $urandom;
			else tl = $urandom_range(0, 32'h0010_0000);
			if ($urandom_range(0, 9) == 0)
				set_all('0, '0, '0, '0, '0, tl, it);
			else
				set_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					tl, it);
			phase_len = sb.iters > 20 ? $urandom_range(4, 10) : $urandom_range(40, 110);
			repeat (phase_len) send_point(rand_point(), rand_point());
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
